>>> rtl/fat_entry_table_access_core_defines.svh
// Assertion macros shared by the FAT table access core.
`ifndef FAT_ENTRY_TABLE_ACCESS_CORE_DEFINES_SVH
`define FAT_ENTRY_TABLE_ACCESS_CORE_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define FETAC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define FETAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/fetac_pkg.sv
`timescale 1ns / 1ps

package fetac_pkg;

  localparam int unsigned TableSizeDefault = 4096;

  // Width of byte offsets and end addresses; holds every offset and the largest table size.
  localparam int unsigned OffW = 17;

  typedef enum logic [1:0] {
    OP_GET  = 2'd0,
    OP_SET  = 2'd1,
    OP_LOAD = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    FT_12  = 2'd0,
    FT_16  = 2'd1,
    FT_32  = 2'd2,
    FT_BAD = 2'd3
  } fat_type_e;

  localparam logic [31:0] Fat12Mask     = 32'h0000_0FFF;
  localparam logic [31:0] Fat12HighKeep = 32'h0000_F000;
  localparam logic [31:0] Fat12LowKeep  = 32'h0000_000F;
  localparam logic [31:0] Fat32Mask     = 32'h0FFF_FFFF;
  localparam logic [31:0] Fat32Keep     = 32'hF000_0000;

endpackage

>>> rtl/fat_entry_table_access_core.sv
`timescale 1ns / 1ps
// FAT12/FAT16/FAT32 table access core.
// Input items arrive on the s_axis channel: op, index and value packed in
// s_axis_tdata. Each item gives exactly one result item on the m_axis channel:
// the entry in m_axis_tdata and the range error flag in m_axis_tuser.
// The table type register is written through cfg_we_i and cfg_wdata_i; the user
// must write it only while the core is idle, which the core does not enforce.
// The table lives in four byte-lane memories, so any four consecutive bytes
// are read together and written back together. An item is accepted, its
// bytes are read at the accepting edge, and in ST_BUSY, once the output
// register is free, the modified bytes are written back and the result is
// registered. The core takes no new item until that result is registered;
// s_axis_tready is low from each acceptance until then.
// When the receiver stalls, the result waits in the output register; the
// core takes one more item and then holds it until the output register frees.
// Reset clears the control state and sets the table type to FAT12. The table
// contents are undefined until loaded; there is no clearing pass.

`include "fat_entry_table_access_core_defines.svh"

module fat_entry_table_access_core #(
  parameter int unsigned TABLE_SIZE = fetac_pkg::TableSizeDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] op, [13:2] index, [45:14] value, [47:46] zero
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] entry
  output logic [31:0] m_axis_tdata,
  // [0] range_error
  output logic        m_axis_tuser
);

  localparam int unsigned Rows = (TABLE_SIZE + 3) / 4;
  localparam int unsigned RowW = $clog2(Rows);
  localparam int unsigned AddrW = RowW + 2;
  localparam int unsigned OffW = fetac_pkg::OffW;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_e;

  state_e state_q;
  fetac_pkg::fat_type_e type_q;

  fetac_pkg::op_e in_op;
  logic [11:0] in_idx;
  logic [31:0] in_val;
  logic [OffW-1:0] off_d;
  logic [2:0] n_d;
  logic fits_d;
  logic s_acc;

  fetac_pkg::op_e op_q;
  fetac_pkg::fat_type_e ft_q;
  logic odd_q;
  logic [1:0] off_lo_q;
  logic [2:0] n_q;
  logic fits_q;
  logic [31:0] val_q;

  logic [RowW-1:0] row_d [4];
  logic [RowW-1:0] row_q [4];
  logic [7:0] rdata_q [4];
  logic [3:0] lane_we;
  logic [7:0] lane_wdata [4];

  logic [31:0] rw;
  logic [15:0] w16;
  logic [31:0] nw;
  logic wr_en;
  logic [31:0] entry_d;
  logic rerr_d;
  logic done;

  logic m_tvalid_q;
  logic [31:0] entry_q;
  logic rerr_q;

  assign in_op  = fetac_pkg::op_e'(s_axis_tdata[1:0]);
  assign in_idx = s_axis_tdata[13:2];
  assign in_val = s_axis_tdata[45:14];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign done = !m_tvalid_q || m_axis_tready;

  // Byte offset and byte count of the access.
  always_comb begin
    off_d = '0;
    n_d = 3'd0;
    if (in_op == fetac_pkg::OP_LOAD) begin
      off_d = {5'b0, in_idx};
      n_d = 3'd1;
    end else begin
      case (type_q)
        fetac_pkg::FT_12: begin
          off_d = {5'b0, in_idx} + {6'b0, in_idx[11:1]};
          n_d = 3'd2;
        end
        fetac_pkg::FT_16: begin
          off_d = {4'b0, in_idx, 1'b0};
          n_d = 3'd2;
        end
        fetac_pkg::FT_32: begin
          off_d = {3'b0, in_idx, 2'b0};
          n_d = 3'd4;
        end
        default: begin
          off_d = '0;
          n_d = 3'd0;
        end
      endcase
    end
    fits_d = (off_d + {14'b0, n_d}) <= OffW'(TABLE_SIZE);
  end

  always_comb begin : p_rows
    logic [1:0] lofs;
    logic [OffW-1:0] laddr;
    for (int k = 0; k < 4; k++) begin
      lofs = 2'(k) - off_d[1:0];
      laddr = off_d + {{(OffW-2){1'b0}}, lofs};
      row_d[k] = laddr[AddrW-1:2];
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_lane
    logic [7:0] mem_q [Rows];

    always_ff @(posedge clk_i) begin
      if (lane_we[k]) begin
        mem_q[row_q[k]] <= lane_wdata[k];
      end
      if (s_acc) begin
        rdata_q[k] <= mem_q[row_d[k]];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      op_q <= in_op;
      ft_q <= type_q;
      odd_q <= in_idx[0];
      off_lo_q <= off_d[1:0];
      n_q <= n_d;
      fits_q <= fits_d;
      val_q <= in_val;
      row_q <= row_d;
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      rw[8*j +: 8] = rdata_q[2'(j) + off_lo_q];
    end
  end

  assign w16 = rw[15:0];

  always_comb begin
    entry_d = '0;
    rerr_d = 1'b0;
    nw = '0;
    wr_en = 1'b0;
    case (op_q)
      fetac_pkg::OP_GET: begin
        if (ft_q == fetac_pkg::FT_BAD) begin
          entry_d = '1;
        end else if (!fits_q) begin
          rerr_d = 1'b1;
        end else begin
          case (ft_q)
            fetac_pkg::FT_12: begin
              entry_d = odd_q ? {20'b0, w16[15:4]} : ({16'b0, w16} & fetac_pkg::Fat12Mask);
            end
            fetac_pkg::FT_16: entry_d = {16'b0, w16};
            default:          entry_d = rw & fetac_pkg::Fat32Mask;
          endcase
        end
      end
      fetac_pkg::OP_SET: begin
        if (ft_q != fetac_pkg::FT_BAD) begin
          if (!fits_q) begin
            rerr_d = 1'b1;
          end else begin
            wr_en = 1'b1;
            case (ft_q)
              fetac_pkg::FT_12: begin
                if (odd_q) begin
                  nw = ({16'b0, w16} & fetac_pkg::Fat12LowKeep)
                     | ((val_q & fetac_pkg::Fat12Mask) << 4);
                end else begin
                  nw = ({16'b0, w16} & fetac_pkg::Fat12HighKeep)
                     | (val_q & fetac_pkg::Fat12Mask);
                end
              end
              fetac_pkg::FT_16: nw = {16'b0, val_q[15:0]};
              default: nw = (rw & fetac_pkg::Fat32Keep) | (val_q & fetac_pkg::Fat32Mask);
            endcase
          end
        end
      end
      fetac_pkg::OP_LOAD: begin
        if (!fits_q) begin
          rerr_d = 1'b1;
        end else begin
          wr_en = 1'b1;
          nw = {24'b0, val_q[7:0]};
        end
      end
      default: begin
        entry_d = '0;
      end
    endcase
  end

  always_comb begin : p_wr
    logic [1:0] lofs;
    for (int k = 0; k < 4; k++) begin
      lofs = 2'(k) - off_lo_q;
      lane_wdata[k] = nw[8*lofs +: 8];
      lane_we[k] = wr_en && (state_q == ST_BUSY) && done && ({1'b0, lofs} < n_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      type_q <= fetac_pkg::FT_12;
      m_tvalid_q <= 1'b0;
      entry_q <= '0;
      rerr_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        type_q <= fetac_pkg::fat_type_e'(cfg_wdata_i);
      end
      if ((state_q == ST_IDLE) && m_tvalid_q && m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_acc) begin
            state_q <= ST_BUSY;
          end
        end
        ST_BUSY: begin
          if (done) begin
            state_q <= ST_IDLE;
            m_tvalid_q <= 1'b1;
            entry_q <= entry_d;
            rerr_q <= rerr_d;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata = entry_q;
  assign m_axis_tuser = rerr_q;

  `FETAC_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, s_acc, state_q == ST_BUSY)
  `FETAC_ASSERT_IMPLIES(a_write_at_retire, clk_i, rst_ni, |lane_we, (state_q == ST_BUSY) && done)
  `FETAC_ASSERT_IMPLIES(a_result_after_busy, clk_i, rst_ni, $rose(m_tvalid_q), $past(state_q) == ST_BUSY)

endmodule
